@@ rtl/bqf_pkg.sv @@
// Shared types and constants of the multichannel biquad filter.
`default_nettype none
package bqf_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int COEF_W      = 32;
	localparam int CH_W        = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int NUM_COEFS   = 5;

	localparam logic [CFG_IDX_W-1:0] REG_B0       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B1       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B2       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_A1       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A2       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 3'd5;

	localparam logic [CH_W-1:0] CHANNELS_RESET = 3'd2;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]      coef_t;
	typedef logic [CH_W-1:0]               chan_t;

	// Per-channel history word kept in the memory.
	typedef struct packed {
		sample_t x1;
		sample_t x2;
		sample_t y1;
		sample_t y2;
	} hist_t;

endpackage
`default_nettype wire

@@ rtl/bqf_sample_if.sv @@
// Input sample channel: valid/ready handshake with sample, channel and frame marker.
`default_nettype none
interface bqf_sample_if;
	import bqf_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_in;
	chan_t   channel;
	logic    frame_end_in;

	modport source(output valid, sample_in, channel, frame_end_in, input ready);
	modport sink(input valid, sample_in, channel, frame_end_in, output ready);
endinterface
`default_nettype wire

@@ rtl/bqf_result_if.sv @@
// Result channel: valid/ready handshake with filtered sample and tags.
`default_nettype none
interface bqf_result_if;
	import bqf_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_out;
	chan_t   channel_out;
	logic    frame_end_out;
	logic    channel_error;

	modport source(output valid, sample_out, channel_out, frame_end_out, channel_error,
		input ready);
	modport sink(input valid, sample_out, channel_out, frame_end_out, channel_error,
		output ready);
endinterface
`default_nettype wire

@@ rtl/bqf_cfg_if.sv @@
// Configuration write channel: valid/ready handshake with register index and data.
`default_nettype none
interface bqf_cfg_if;
	import bqf_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [COEF_W-1:0]    data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/bqf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bqf_ram #(
	parameter int WIDTH  = 96,
	parameter int DEPTH  = 7,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

@@ rtl/multichannel_biquad_filter.sv @@
// Top level of the multichannel direct form I biquad filter.
//
// Usage:
//   sample_chan carries one signed sample per transaction, tagged with its
//   channel and a frame end marker. result_chan returns exactly one result per
//   input transaction, in order: the filtered sample, or the input sample with
//   channel_error set when the channel is not below channels_in_use.
//   cfg writes coefficients (index 0..4, Q4.28) and channels_in_use (index 5);
//   it is always ready. Write it only while the filter is idle. Any coefficient
//   write clears the history of every channel.
// Path: a sample runs through the stage 1, 2 and 3 and output registers.
// Throughput: one transaction per cycle while result_chan is ready and no
//   filtered sample in flight shares its channel. A sample whose channel
//   matches a filtered sample still in the multiply or sum stage waits, so one
//   channel alone is paced by the feedback loop through multiply, sum, round
//   and saturate.
// History sits in one RAM word per channel (x1, x2, y1, y2), read at accept
//   and written back when the result leaves the last stage; the write of the
//   same edge is forwarded into the read.
// Reset: history valid bits clear (all channels read as zero), coefficients
//   return to unity pass-through, channels_in_use returns to 2.
// Stall: when result_chan is not ready the output register holds; the stages
//   behind it keep filling until full, then sample_chan.ready drops.
`default_nettype none
module multichannel_biquad_filter #(
	parameter int MAX_CHANNELS   = 7,
	parameter int COEF_FRAC_BITS = 28
) (
	input wire logic clk,
	input wire logic arst_n,
	bqf_sample_if.sink   sample_chan,
	bqf_result_if.source result_chan,
	bqf_cfg_if.sink      cfg
);
	import bqf_pkg::*;

	localparam int AW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int PW     = COEF_W + SAMPLE_BITS;
	localparam int ACC_W  = PW + 3;
	localparam int CMP_W  = 5;
	localparam logic [CMP_W-1:0] MAXC = CMP_W'(MAX_CHANNELS);
	localparam coef_t UNITY = coef_t'(64'sd1 <<< COEF_FRAC_BITS);
	localparam logic signed [ACC_W-1:0] HALF =
		ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
	localparam logic signed [ACC_W-1:0] SAT_HI =
		ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

	// ---------------- configuration ----------------
	coef_t b0_q, b1_q, b2_q, a1_q, a2_q;
	chan_t chans_q;
	logic  cfg_wr;
	logic  coef_wr;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;
	assign coef_wr   = cfg_wr && (cfg.index < REG_CHANNELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q    <= UNITY;
			b1_q    <= '0;
			b2_q    <= '0;
			a1_q    <= '0;
			a2_q    <= '0;
			chans_q <= CHANNELS_RESET;
		end else if (cfg_wr) begin
			case (cfg.index)
				REG_B0:       b0_q    <= coef_t'(cfg.data);
				REG_B1:       b1_q    <= coef_t'(cfg.data);
				REG_B2:       b2_q    <= coef_t'(cfg.data);
				REG_A1:       a1_q    <= coef_t'(cfg.data);
				REG_A2:       a2_q    <= coef_t'(cfg.data);
				REG_CHANNELS: chans_q <= cfg.data[CH_W-1:0];
				default:      ;
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	logic v1_q, v2_q, v3_q, ov_q;
	logic adv1, adv2, adv3, accept;
	logic e1_s1, e2_s2, e3_s3;
	chan_t ch_s1, ch_s2, ch_s3;
	logic in_err, hazard;
	logic [AW-1:0] in_addr;
	hist_t new_hist;
	sample_t y_c;

	assign adv3 = v3_q && (!ov_q || result_chan.ready);
	assign adv2 = v2_q && (!v3_q || adv3);
	assign adv1 = v1_q && (!v2_q || adv2);

	// Pass-through when the channel is not configured or beyond storage.
	assign in_err = (CMP_W'(chans_q) > MAXC)
		|| (CMP_W'(sample_chan.channel) >= CMP_W'(chans_q))
		|| (CMP_W'(sample_chan.channel) >= MAXC);
	assign in_addr = AW'(sample_chan.channel);

	// Hold a sample whose channel history is still being computed.
	assign hazard = !in_err && (
		(v1_q && !e1_s1 && (ch_s1 == sample_chan.channel)) ||
		(v2_q && !e2_s2 && (ch_s2 == sample_chan.channel)) ||
		(v3_q && !e3_s3 && (ch_s3 == sample_chan.channel) && !adv3));

	assign sample_chan.ready = (!v1_q || adv1) && !hazard;
	assign accept            = sample_chan.valid && sample_chan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			v1_q <= accept || (v1_q && !adv1);
			v2_q <= adv1 || (v2_q && !adv2);
			v3_q <= adv2 || (v3_q && !adv3);
			ov_q <= adv3 || (ov_q && !result_chan.ready);
		end
	end

	// ---------------- history memory ----------------
	logic [MAX_CHANNELS-1:0] hv_q;
	logic hist_wr;
	hist_t rd_hist;

	assign hist_wr = adv3 && !e3_s3;

	bqf_ram #(
		.WIDTH ($bits(hist_t)),
		.DEPTH (MAX_CHANNELS),
		.ADDR_W(AW)
	) u_hist_ram (
		.clk    (clk),
		.wr_en  (hist_wr),
		.wr_addr(AW'(ch_s3)),
		.wr_data(new_hist),
		.rd_en  (accept),
		.rd_addr(in_addr),
		.rd_data(rd_hist)
	);

	// Valid bits stand in for clearing: an entry not yet written reads zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q <= '0;
		end else if (coef_wr) begin
			hv_q <= '0;
		end else if (hist_wr) begin
			hv_q[AW'(ch_s3)] <= 1'b1;
		end
	end

	// ---------------- stage 1: history select, multiply ----------------
	logic    hv_s1, fwd_s1, fe_s1;
	hist_t   fwd_hist_s1, hist_c;
	sample_t x_s1;
	logic signed [PW-1:0] p0_c, p1_c, p2_c, p3_c, p4_c;

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1        <= sample_chan.sample_in;
			ch_s1       <= sample_chan.channel;
			fe_s1       <= sample_chan.frame_end_in;
			e1_s1       <= in_err;
			hv_s1       <= hv_q[in_addr];
			// Catch the write-back landing on this edge.
			fwd_s1      <= hist_wr && (ch_s3 == sample_chan.channel);
			fwd_hist_s1 <= new_hist;
		end
	end

	always_comb begin
		if (fwd_s1) begin
			hist_c = fwd_hist_s1;
		end else if (hv_s1) begin
			hist_c = rd_hist;
		end else begin
			hist_c = '0;
		end
	end

	assign p0_c = PW'(b0_q) * PW'(x_s1);
	assign p1_c = PW'(b1_q) * PW'(hist_c.x1);
	assign p2_c = PW'(b2_q) * PW'(hist_c.x2);
	assign p3_c = PW'(a1_q) * PW'(hist_c.y1);
	assign p4_c = PW'(a2_q) * PW'(hist_c.y2);

	// ---------------- stage 2: partial sums ----------------
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2;
	sample_t x_s2, x1_s2, y1_s2;
	logic    fe_s2;

	always_ff @(posedge clk) begin
		if (adv1) begin
			p0_s2 <= p0_c;
			p1_s2 <= p1_c;
			p2_s2 <= p2_c;
			p3_s2 <= p3_c;
			p4_s2 <= p4_c;
			x_s2  <= x_s1;
			x1_s2 <= hist_c.x1;
			y1_s2 <= hist_c.y1;
			ch_s2 <= ch_s1;
			fe_s2 <= fe_s1;
			e2_s2 <= e1_s1;
		end
	end

	// ---------------- stage 3: final sum, round, saturate ----------------
	logic signed [ACC_W-1:0] ff_s3, fb_s3, acc_c, q_c;
	sample_t x_s3, x1_s3, y1_s3;
	logic    fe_s3;

	always_ff @(posedge clk) begin
		if (adv2) begin
			ff_s3 <= ACC_W'(p0_s2) + ACC_W'(p1_s2) + ACC_W'(p2_s2);
			fb_s3 <= ACC_W'(p3_s2) + ACC_W'(p4_s2);
			x_s3  <= x_s2;
			x1_s3 <= x1_s2;
			y1_s3 <= y1_s2;
			ch_s3 <= ch_s2;
			fe_s3 <= fe_s2;
			e3_s3 <= e2_s2;
		end
	end

	// Round half up, then clamp to the sample range.
	assign acc_c = ff_s3 - fb_s3 + HALF;
	assign q_c   = acc_c >>> COEF_FRAC_BITS;

	always_comb begin
		if (q_c > SAT_HI) begin
			y_c = sample_t'(SAT_HI);
		end else if (q_c < SAT_LO) begin
			y_c = sample_t'(SAT_LO);
		end else begin
			y_c = q_c[SAMPLE_BITS-1:0];
		end
	end

	assign new_hist = '{x1: x_s3, x2: x1_s3, y1: y_c, y2: y1_s3};

	// ---------------- output register ----------------
	sample_t out_sample_q;
	chan_t   out_ch_q;
	logic    out_fe_q, out_err_q;

	always_ff @(posedge clk) begin
		if (adv3) begin
			out_sample_q <= e3_s3 ? x_s3 : y_c;
			out_ch_q     <= ch_s3;
			out_fe_q     <= fe_s3;
			out_err_q    <= e3_s3;
		end
	end

	assign result_chan.valid         = ov_q;
	assign result_chan.sample_out    = out_sample_q;
	assign result_chan.channel_out   = out_ch_q;
	assign result_chan.frame_end_out = out_fe_q;
	assign result_chan.channel_error = out_err_q;
endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the multichannel direct form I biquad filter.
`default_nettype none
module testbench;
	import bqf_pkg::*;

	localparam int MAX_CH       = 7;
	localparam int COEF_FRAC    = 28;
	localparam int CH_MAX       = (1 << CH_W) - 1;
	localparam int PIPE_LATENCY = 3;
	localparam int HOLD_CYCLES  = 150;
	localparam int MAX_PRINTED  = 25;
	localparam int DRAIN_GUARD  = 50000;

	// Register indexes past channels_in_use decode to nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

	// Q4.28 coefficient values used by the directed tests.
	localparam coef_t COEF_ONE     = 32'sh1000_0000;
	localparam coef_t COEF_HALF    = 32'sh0800_0000;
	localparam coef_t COEF_QUARTER = 32'sh0400_0000;
	localparam coef_t COEF_EIGHTH  = 32'sh0200_0000;
	localparam coef_t COEF_MAX     = 32'sh7FFF_FFFF;
	localparam coef_t COEF_MIN     = 32'sh8000_0000;
	localparam coef_t COEF_ZERO    = 32'sh0000_0000;

	localparam sample_t SAMPLE_MAX = 24'sh7F_FFFF;
	localparam sample_t SAMPLE_MIN = 24'sh80_0000;
	localparam longint  SAT_MAX    = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint  SAT_MIN    = -SAT_MAX - 1;
	localparam longint  ROUND_HALF = longint'(1) <<< (COEF_FRAC - 1);

	typedef struct {
		sample_t sample_val;
		chan_t   channel;
		logic    frame_end;
		logic    error;
	} filter_result_t;

	logic clk = 1'b0;
	logic arst_n;

	bqf_sample_if sample_bus();
	bqf_result_if result_bus();
	bqf_cfg_if    cfg_bus();

	multichannel_biquad_filter #(
		.MAX_CHANNELS(MAX_CH),
		.COEF_FRAC_BITS(COEF_FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_chan(sample_bus),
		.result_chan(result_bus),
		.cfg(cfg_bus)
	);

	always #4 clk = ~clk;

	// Shadow of the filter: coefficients, channel count and per-channel history.
	coef_t   shadow_coef [NUM_COEFS];
	chan_t   shadow_channels;
	sample_t hist_x1 [MAX_CH];
	sample_t hist_x2 [MAX_CH];
	sample_t hist_y1 [MAX_CH];
	sample_t hist_y2 [MAX_CH];

	filter_result_t pending_filtered [$];
	filter_result_t head_result;

	int mismatch_count  = 0;
	int samples_sent    = 0;
	int results_checked = 0;
	int reg_writes      = 0;
	int send_idle_pct   = 0;
	int recv_stall_pct  = 0;

	// Long receiver hold-off: a toggle of hold_req asks for one, the hold counter counts it.
	bit hold_req  = 1'b0;
	bit hold_ack  = 1'b0;
	int hold_left = 0;

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	function automatic void clear_history();
		for (int i = 0; i < MAX_CH; i++) begin
			hist_x1[i] = '0;
			hist_x2[i] = '0;
			hist_y1[i] = '0;
			hist_y2[i] = '0;
		end
	endfunction

	function automatic void reset_shadow();
		shadow_coef[REG_B0] = COEF_ONE;
		shadow_coef[REG_B1] = COEF_ZERO;
		shadow_coef[REG_B2] = COEF_ZERO;
		shadow_coef[REG_A1] = COEF_ZERO;
		shadow_coef[REG_A2] = COEF_ZERO;
		shadow_channels = CHANNELS_RESET;
		clear_history();
	endfunction

	// Compute the filter output for one accepted sample and advance the history.
	function automatic filter_result_t filter_sample(sample_t x, chan_t ch, logic fe);
		filter_result_t r;
		longint acc;
		longint y;
		r.channel   = ch;
		r.frame_end = fe;
		if (ch >= shadow_channels || ch >= MAX_CH) begin
			// Channel not in use: pass the sample, flag it, leave history alone.
			r.sample_val = x;
			r.error      = 1'b1;
			return r;
		end
		acc = longint'(shadow_coef[REG_B0]) * longint'(x)
			+ longint'(shadow_coef[REG_B1]) * longint'(hist_x1[ch])
			+ longint'(shadow_coef[REG_B2]) * longint'(hist_x2[ch])
			- longint'(shadow_coef[REG_A1]) * longint'(hist_y1[ch])
			- longint'(shadow_coef[REG_A2]) * longint'(hist_y2[ch]);
		// Round half up, then saturate only the final value.
		y = (acc + ROUND_HALF) >>> COEF_FRAC;
		if (y > SAT_MAX)
			y = SAT_MAX;
		if (y < SAT_MIN)
			y = SAT_MIN;
		hist_x2[ch] = hist_x1[ch];
		hist_x1[ch] = x;
		hist_y2[ch] = hist_y1[ch];
		hist_y1[ch] = sample_t'(y);
		r.sample_val = sample_t'(y);
		r.error      = 1'b0;
		return r;
	endfunction

	// Offer one sample, hold it until accepted, then idle at the phase's rate.
	task automatic send_sample(input sample_t x, input chan_t ch, input logic fe);
		bit dropped;
		sample_bus.valid        <= 1'b1;
		sample_bus.sample_in    <= x;
		sample_bus.channel      <= ch;
		sample_bus.frame_end_in <= fe;
		do @(posedge clk); while (!sample_bus.ready);
		pending_filtered.push_back(filter_sample(x, ch, fe));
		samples_sent++;
		dropped = 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			if (!dropped) begin
				sample_bus.valid <= 1'b0;
				dropped = 1'b1;
			end
			@(posedge clk);
		end
	endtask

	// Drop valid, wait out every pending result and then the pipeline latency.
	task automatic wait_filter_idle();
		int guard;
		sample_bus.valid <= 1'b0;
		guard = 0;
		while (pending_filtered.size() != 0 && guard < DRAIN_GUARD) begin
			@(posedge clk);
			guard++;
		end
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	// Write one register; valid stays up so back-to-back writes need no gap.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		reg_writes++;
		if (idx < REG_CHANNELS) begin
			// Any coefficient write wipes the history of every channel.
			shadow_coef[idx] = coef_t'(value);
			clear_history();
		end else if (idx == REG_CHANNELS) begin
			shadow_channels = value[CH_W-1:0];
		end
	endtask

	task automatic cfg_release();
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input coef_t b0, input coef_t b1, input coef_t b2,
		input coef_t a1, input coef_t a2, input chan_t count);
		wait_filter_idle();
		write_reg(REG_B0, b0);
		write_reg(REG_B1, b1);
		write_reg(REG_B2, b2);
		write_reg(REG_A1, a1);
		write_reg(REG_A2, a2);
		write_reg(REG_CHANNELS, COEF_W'(count));
		cfg_release();
	endtask

	task automatic set_channel_count(input chan_t count);
		wait_filter_idle();
		write_reg(REG_CHANNELS, COEF_W'(count));
		cfg_release();
	endtask

	function automatic sample_t random_sample();
		if ($urandom_range(7) == 0) begin
			case ($urandom_range(3))
				0: return SAMPLE_MAX;
				1: return SAMPLE_MIN;
				2: return sample_t'(0);
				default: return sample_t'(-1);
			endcase
		end
		return sample_t'($urandom());
	endfunction

	// Coefficient in [-0.5, +0.5], keeps most filters well behaved.
	function automatic coef_t mild_coef();
		return coef_t'($urandom_range(32'h1000_0000)) - COEF_HALF;
	endfunction

	function automatic coef_t extreme_coef();
		case ($urandom_range(3))
			0: return COEF_MAX;
			1: return COEF_MIN;
			2: return COEF_ZERO;
			default: return COEF_ONE;
		endcase
	endfunction

	task automatic configure_random(input chan_t count);
		int mode;
		mode = $urandom_range(9);
		if (mode < 5)
			configure(mild_coef(), mild_coef(), mild_coef(), mild_coef(), mild_coef(), count);
		else if (mode < 8)
			configure(coef_t'($urandom()), coef_t'($urandom()), coef_t'($urandom()),
				coef_t'($urandom()), coef_t'($urandom()), count);
		else
			configure(extreme_coef(), extreme_coef(), extreme_coef(), extreme_coef(),
				extreme_coef(), count);
	endtask

	// Send whole interleaved frames mostly, with stray samples on any channel mixed in.
	task automatic send_frames(input int n_items);
		int sent;
		int k;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 70 && shadow_channels != 0) begin
				for (k = 0; k < shadow_channels; k++) begin
					send_sample(random_sample(), chan_t'(k), k == shadow_channels - 1);
					sent++;
				end
			end else begin
				send_sample(random_sample(), chan_t'($urandom_range(CH_MAX)),
					1'($urandom_range(1)));
				sent++;
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// Directed tests
	// ---------------------------------------------------------------------

	// Unity pass-through on two channels straight out of reset, and flags on channels 2 and 7.
	task automatic test_reset_defaults();
		send_sample(SAMPLE_MAX, 3'd0, 1'b0);
		send_sample(SAMPLE_MIN, 3'd1, 1'b1);
		send_sample(sample_t'(-1), 3'd0, 1'b0);
		send_sample(sample_t'(12345), 3'd2, 1'b0);
		send_sample(SAMPLE_MIN, 3'd7, 1'b1);
	endtask

	// Half-LSB rounding both signs, and saturation at both ends of the range.
	task automatic test_rounding_saturation();
		configure(COEF_HALF, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, 3'd2);
		send_sample(sample_t'(1), 3'd0, 1'b0);
		send_sample(sample_t'(-1), 3'd1, 1'b0);
		send_sample(sample_t'(3), 3'd0, 1'b0);
		send_sample(sample_t'(-3), 3'd1, 1'b1);
		configure(COEF_MAX, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, 3'd2);
		send_sample(SAMPLE_MAX, 3'd0, 1'b0);
		send_sample(SAMPLE_MIN, 3'd1, 1'b0);
		configure(COEF_MIN, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, 3'd2);
		send_sample(SAMPLE_MIN, 3'd0, 1'b1);
		send_sample(SAMPLE_MAX, 3'd1, 1'b0);
	endtask

	// Full biquad with feedback; includes back-to-back samples of one channel.
	task automatic test_feedback_history();
		configure(COEF_HALF, COEF_QUARTER, -COEF_EIGHTH, -COEF_HALF, COEF_QUARTER, 3'd3);
		send_sample(sample_t'(1 << 20), 3'd0, 1'b0);
		send_sample(sample_t'(-(1 << 20)), 3'd1, 1'b0);
		send_sample(sample_t'(0), 3'd0, 1'b0);
		send_sample(sample_t'(500000), 3'd2, 1'b1);
		send_sample(sample_t'(0), 3'd1, 1'b0);
		send_sample(sample_t'(0), 3'd0, 1'b0);
		send_sample(sample_t'(0), 3'd0, 1'b0);
	endtask

	// A channel count write keeps history; unused indexes change nothing.
	task automatic test_register_decoding();
		set_channel_count(3'd4);
		send_sample(sample_t'(0), 3'd0, 1'b0);
		wait_filter_idle();
		write_reg(REG_UNUSED_A, $urandom());
		write_reg(REG_UNUSED_B, $urandom());
		cfg_release();
		send_sample(sample_t'(0), 3'd1, 1'b0);
		send_sample(sample_t'(777), 3'd3, 1'b1);
	endtask

	// Zero channels flags everything; seven channels still flags channel seven.
	task automatic test_channel_limits();
		set_channel_count(3'd0);
		send_sample(sample_t'(4242), 3'd0, 1'b0);
		set_channel_count(3'd7);
		send_sample(sample_t'(-4242), 3'd6, 1'b0);
		send_sample(sample_t'(99), 3'd7, 1'b1);
	endtask

	// ---------------------------------------------------------------------
	// Random tests
	// ---------------------------------------------------------------------

	task automatic run_traffic_phase(input int n_items, input int send_pct, input int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		// Sometimes change only the channel count, so history carries over.
		if ($urandom_range(2) == 0)
			set_channel_count(chan_t'($urandom_range(1, MAX_CH)));
		else
			configure_random(chan_t'($urandom_range(1, MAX_CH)));
		send_frames(n_items);
	endtask

	task automatic test_random_traffic();
		run_traffic_phase(130, 0, 0);
		run_traffic_phase(130, 69, 0);
		run_traffic_phase(130, 0, 69);
		run_traffic_phase(130, 6, 6);
	endtask

	// One channel back to back: every sample depends on the one just before it.
	task automatic test_single_channel();
		int k;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		configure_random(3'd1);
		for (k = 0; k < 40; k++)
			send_sample(random_sample(), 3'd0, k == 39);
	endtask

	// Hold the receiver off for a long stretch while samples keep coming.
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		configure_random(3'd5);
		hold_req <= ~hold_req;
		send_frames(60);
	endtask

	// ---------------------------------------------------------------------
	// Hold-off counter: start a long hold on request, count it down in cycles.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// ---------------------------------------------------------------------
	// Receiver: check each result transaction, then drive ready for the next cycle.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (result_bus.valid && result_bus.ready) begin
			if (pending_filtered.size() == 0) begin
				report_mismatch($sformatf("result with no pending sample: %0d on channel %0d",
					result_bus.sample_out, result_bus.channel_out));
			end else begin
				head_result = pending_filtered.pop_front();
				results_checked++;
				if (result_bus.sample_out !== head_result.sample_val)
					report_mismatch($sformatf("sample_out %0d, want %0d (channel %0d)",
						result_bus.sample_out, head_result.sample_val, head_result.channel));
				if (result_bus.channel_out !== head_result.channel)
					report_mismatch($sformatf("channel_out %0d, want %0d",
						result_bus.channel_out, head_result.channel));
				if (result_bus.frame_end_out !== head_result.frame_end)
					report_mismatch($sformatf("frame_end_out %0b, want %0b (channel %0d)",
						result_bus.frame_end_out, head_result.frame_end, head_result.channel));
				if (result_bus.channel_error !== head_result.error)
					report_mismatch($sformatf("channel_error %0b, want %0b (channel %0d)",
						result_bus.channel_error, head_result.error, head_result.channel));
			end
		end
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else if (hold_req != hold_ack || hold_left != 0) begin
			result_bus.ready <= 1'b0;
		end else begin
			result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Hard stop in case the filter hangs.
	initial begin
		#2_400_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		// Drive every input to a known value from time zero.
		sample_bus.valid        <= 1'b0;
		sample_bus.sample_in    <= '0;
		sample_bus.channel      <= '0;
		sample_bus.frame_end_in <= 1'b0;
		cfg_bus.valid           <= 1'b0;
		cfg_bus.index           <= '0;
		cfg_bus.data            <= '0;
		arst_n                  <= 1'b0;
		reset_shadow();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_rounding_saturation();
		test_feedback_history();
		test_register_decoding();
		test_channel_limits();
		test_random_traffic();
		test_single_channel();
		test_backpressure();

		// Drain and flag anything the filter never returned.
		wait_filter_idle();
		if (pending_filtered.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				pending_filtered.size()));

		$display("Summary: %0d samples sent, %0d results checked, %0d register writes.",
			samples_sent, results_checked, reg_writes);
		$display("Summary: rounding, saturation, history, channel limits, idle and stall mixes, long hold-off.");
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
